// ----- design/ccba_pkg.sv -----
`default_nettype none

package ccba_pkg;

   // Default geometry
   localparam int CHANNELS_DEF      = 8;
   localparam int TX_CANDIDATES_DEF = 4;
   localparam int RX_CANDIDATES_DEF = 4;

   // Fixed field widths
   localparam int COUNT_W = 4;
   localparam int CHAN_W  = 3;
   localparam int TAG_W   = 4;

   // Operation and direction codes
   localparam logic MODE_ALLOC   = 1'b0;
   localparam logic MODE_RELEASE = 1'b1;
   localparam logic DIR_TX       = 1'b0;
   localparam logic DIR_RX       = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MARK,
      ST_FREE,
      ST_DONE
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic ready;    // request channel may take a transaction
      logic load;     // capture request
      logic scan;     // test one channel during the downward search
      logic mark;     // write one tag of a granted run
      logic free;     // clear one tag of a released run
      logic fail;     // search exhausted
      logic deliver;  // move the result into the output register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic req_valid;
      logic req_release;
      logic req_beyond;   // release start past the last channel
      logic req_zero;     // allocation of zero blocks
      logic tag_low;      // current tag is 0 or 1
      logic hit;          // free run complete at current channel
      logic at_bottom;    // pointer at the bottom of the search range
      logic at_last;      // pointer at the last channel
      logic mark_last;    // writing the final tag of a run
      logic out_free;     // output register can take a result
   } sts_type;

endpackage

`default_nettype wire

// ----- design/ccba_req_if.sv -----
`default_nettype none

interface ccba_req_if;
   import ccba_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 mode;
   logic                 direction;
   logic [COUNT_W-1:0]   block_count;
   logic [CHAN_W-1:0]    release_channel;

   modport source (output valid, mode, direction, block_count, release_channel,
                   input ready);
   modport sink   (input valid, mode, direction, block_count, release_channel,
                   output ready);
endinterface

`default_nettype wire

// ----- design/ccba_rsp_if.sv -----
`default_nettype none

interface ccba_rsp_if;
   import ccba_pkg::*;

   logic                valid;
   logic                ready;
   logic                success;
   logic [CHAN_W-1:0]   base_channel;

   modport source (output valid, success, base_channel, input ready);
   modport sink   (input valid, success, base_channel, output ready);
endinterface

`default_nettype wire

// ----- design/contiguous_channel_block_allocator_top.sv -----
// Channel   Direction  Transaction carries
// req_chan  in         mode, direction, block_count, release_channel
// rsp_chan  out        success, base_channel
//
// One transaction at a time. An allocation loads the request, tests one
// channel per step of the downward tag scan (at most CHANNELS), writes one
// tag per block (block_count), then hands the result over. A release loads,
// clears one tag per step, then hands over. The single tag read port makes
// the scan and the clearing sequential. Reset clears every tag. A result waiting
// on rsp_chan does not stop the next request from being taken.
`default_nettype none

module contiguous_channel_block_allocator_top #(
   parameter int CHANNELS      = ccba_pkg::CHANNELS_DEF,
   parameter int TX_CANDIDATES = ccba_pkg::TX_CANDIDATES_DEF,
   parameter int RX_CANDIDATES = ccba_pkg::RX_CANDIDATES_DEF
) (
   input  wire          clock,
   input  wire          reset,
   ccba_req_if.sink     req_chan,
   ccba_rsp_if.source   rsp_chan
);
   import ccba_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencer
   ccba_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts_i (sts),
      .cmd_o (cmd)
   );

   // Tag store, search pointer and result registers
   ccba_dpath #(
      .CHANNELS      (CHANNELS),
      .TX_CANDIDATES (TX_CANDIDATES),
      .RX_CANDIDATES (RX_CANDIDATES)
   ) u_dpath (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .rsp   (rsp_chan),
      .cmd_i (cmd),
      .sts_o (sts)
   );

   // Only one datapath operation per cycle
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.scan, cmd.mark, cmd.free, cmd.deliver}))
      else $error("several datapath commands at once");

   // A load leaves the idle state, so never two loads in a row
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !cmd.load)
      else $error("request loaded twice in a row");

   // A new result only appears after a hand-over
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(cmd.deliver))
      else $error("result raised without hand-over");

   // Failed allocation reports base channel zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.success) |-> (rsp_chan.base_channel == '0))
      else $error("failed allocation with non-zero base");

endmodule

`default_nettype wire

// ----- design/ccba_ctrl.sv -----
`default_nettype none

module ccba_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire ccba_pkg::sts_type  sts_i,
   output ccba_pkg::cmd_type       cmd_o
);
   import ccba_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (sts_i.req_valid) begin
               if (sts_i.req_release) begin
                  state_in = sts_i.req_beyond ? ST_DONE : ST_FREE;
               end else begin
                  state_in = sts_i.req_zero ? ST_DONE : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (sts_i.hit) begin
               state_in = ST_MARK;
            end else if (sts_i.at_bottom) begin
               state_in = ST_DONE;
            end
         end
         ST_MARK: begin
            if (sts_i.mark_last) begin
               state_in = ST_DONE;
            end
         end
         ST_FREE: begin
            if (sts_i.tag_low || sts_i.at_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (sts_i.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      cmd_o = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd_o.ready = 1'b1;
            cmd_o.load  = sts_i.req_valid;
         end
         ST_SCAN: begin
            cmd_o.scan = 1'b1;
            cmd_o.fail = !sts_i.hit && sts_i.at_bottom;
         end
         ST_MARK: cmd_o.mark = 1'b1;
         ST_FREE: cmd_o.free = 1'b1;
         ST_DONE: cmd_o.deliver = sts_i.out_free;
         default: cmd_o = '0;
      endcase
   end

endmodule

`default_nettype wire

// ----- design/ccba_dpath.sv -----
`default_nettype none

module ccba_dpath #(
   parameter int CHANNELS      = ccba_pkg::CHANNELS_DEF,
   parameter int TX_CANDIDATES = ccba_pkg::TX_CANDIDATES_DEF,
   parameter int RX_CANDIDATES = ccba_pkg::RX_CANDIDATES_DEF
) (
   input  wire                     clock,
   input  wire                     reset,
   ccba_req_if.sink                req,
   ccba_rsp_if.source              rsp,
   input  wire ccba_pkg::cmd_type  cmd_i,
   output ccba_pkg::sts_type       sts_o
);
   import ccba_pkg::*;

   localparam int PTR_W  = $clog2(CHANNELS);
   localparam int TX_N   = (TX_CANDIDATES < CHANNELS) ? TX_CANDIDATES : CHANNELS;
   localparam int RX_N   = (RX_CANDIDATES < CHANNELS) ? RX_CANDIDATES : CHANNELS;
   localparam bit FULL   = (TX_CANDIDATES == CHANNELS);
   localparam int TX_HI  = FULL ? CHANNELS - 1 : TX_N - 1;
   localparam int RX_LO  = FULL ? 0 : CHANNELS - RX_N;

   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(CHANNELS - 1);
   localparam logic [PTR_W-1:0] PTR_TX_HI = PTR_W'(TX_HI);
   localparam logic [PTR_W-1:0] PTR_RX_LO = PTR_W'(RX_LO);

   logic [TAG_W-1:0]   tags_ff [CHANNELS];
   logic [TAG_W-1:0]   tags_in [CHANNELS];
   logic [PTR_W-1:0]   ptr_ff, ptr_in;
   logic [COUNT_W-1:0] run_ff, run_in;
   logic [COUNT_W-1:0] need_ff, need_in;
   logic [COUNT_W-1:0] left_ff, left_in;
   logic               dir_ff, dir_in;
   logic               res_ok_ff, res_ok_in;
   logic [CHAN_W-1:0]  res_base_ff, res_base_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_success_ff, rsp_success_in;
   logic [CHAN_W-1:0]  rsp_base_ff, rsp_base_in;

   logic [TAG_W-1:0]   tag_cur;
   logic [PTR_W-1:0]   scan_lo;
   logic               tag_zero;
   logic               hit;

   // Current tag, guarded against a pointer past the last channel
   assign tag_cur  = (int'(ptr_ff) < CHANNELS) ? tags_ff[ptr_ff] : '0;
   assign tag_zero = (tag_cur == '0);
   assign hit      = tag_zero && ((run_ff + 1'b1) == need_ff);
   assign scan_lo  = (dir_ff == DIR_RX) ? PTR_RX_LO : '0;

   // Status towards the controller
   always_comb begin
      sts_o             = '0;
      sts_o.req_valid   = req.valid;
      sts_o.req_release = (req.mode == MODE_RELEASE);
      sts_o.req_beyond  = (int'(req.release_channel) >= CHANNELS);
      sts_o.req_zero    = (req.block_count == '0);
      sts_o.tag_low     = (tag_cur <= TAG_W'(1));
      sts_o.hit         = hit;
      sts_o.at_bottom   = (ptr_ff == scan_lo);
      sts_o.at_last     = (ptr_ff == PTR_LAST);
      sts_o.mark_last   = (left_ff == COUNT_W'(1));
      sts_o.out_free    = !rsp_valid_ff || rsp.ready;
   end

   // Next values
   always_comb begin
      tags_in        = tags_ff;
      ptr_in         = ptr_ff;
      run_in         = run_ff;
      need_in        = need_ff;
      left_in        = left_ff;
      dir_in         = dir_ff;
      res_ok_in      = res_ok_ff;
      res_base_in    = res_base_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_success_in = rsp_success_ff;
      rsp_base_in    = rsp_base_ff;

      if (cmd_i.load) begin
         need_in     = req.block_count;
         dir_in      = req.direction;
         run_in      = '0;
         res_base_in = '0;
         res_ok_in   = (req.mode == MODE_RELEASE) || (req.block_count != '0);
         if (req.mode == MODE_RELEASE) begin
            ptr_in = PTR_W'(req.release_channel);
         end else if (FULL || req.direction == DIR_RX) begin
            ptr_in = PTR_LAST;
         end else begin
            ptr_in = PTR_TX_HI;
         end
      end

      // Downward search: count consecutive free channels
      if (cmd_i.scan) begin
         run_in = tag_zero ? run_ff + 1'b1 : '0;
         if (hit) begin
            res_base_in = CHAN_W'(ptr_ff);
            left_in     = need_ff;
         end else begin
            ptr_in = ptr_ff - 1'b1;
         end
      end

      if (cmd_i.fail) begin
         res_ok_in = 1'b0;
      end

      // Tag the run from its bottom upward: n, n-1, ... 1
      if (cmd_i.mark) begin
         tags_in[ptr_ff] = TAG_W'(left_ff);
         left_in         = left_ff - 1'b1;
         ptr_in          = ptr_ff + 1'b1;
      end

      if (cmd_i.free) begin
         tags_in[ptr_ff] = '0;
         ptr_in          = ptr_ff + 1'b1;
      end

      if (cmd_i.deliver) begin
         rsp_valid_in   = 1'b1;
         rsp_success_in = res_ok_ff;
         rsp_base_in    = res_base_ff;
      end
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            tags_ff[i] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         tags_ff      <= tags_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff         <= ptr_in;
      run_ff         <= run_in;
      need_ff        <= need_in;
      left_ff        <= left_in;
      dir_ff         <= dir_in;
      res_ok_ff      <= res_ok_in;
      res_base_ff    <= res_base_in;
      rsp_success_ff <= rsp_success_in;
      rsp_base_ff    <= rsp_base_in;
   end

   assign req.ready        = cmd_i.ready;
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.success      = rsp_success_ff;
   assign rsp.base_channel = rsp_base_ff;

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ccba_pkg::*;

   // Geometry of the instance under test
   localparam int NCH    = CHANNELS_DEF;
   localparam int TXC    = TX_CANDIDATES_DEF;
   localparam int RXC    = RX_CANDIDATES_DEF;
   localparam int TX_TOP = ((TXC < NCH) ? TXC : NCH) - 1;
   localparam int RX_LOW = (RXC < NCH) ? (NCH - RXC) : 0;

   localparam int DRAIN_LIMIT = 5000;
   localparam int SETTLE      = 2 * (2 + NCH + 8);

   typedef struct packed {
      logic              success;
      logic [CHAN_W-1:0] base;
   } outcome_type;

   logic clock;
   logic reset;

   ccba_req_if req_chan ();
   ccba_rsp_if rsp_chan ();

   contiguous_channel_block_allocator_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Predictor state and scoreboard
   logic [TAG_W-1:0] chan_tags [NCH];
   outcome_type      expected_outcomes [$];
   int               error_count;
   int               n_granted;
   int               n_refused;
   int               n_released;
   bit               req_idle_on;
   bit               rsp_stall_on;

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("tb: FAIL");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("tb: mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap(input bit enabled);
      int r;
      r = $urandom_range(0, 99);
      if (!enabled || r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(6, 40);
   endfunction

   // Allocator behaviour: updates the tag copy and returns the expected response
   function automatic outcome_type predict_outcome(input logic mode, input logic dir,
                                                   input logic [COUNT_W-1:0] count,
                                                   input logic [CHAN_W-1:0] chan);
      outcome_type      res;
      int               lo;
      int               hi;
      int               n;
      int               top;
      int               k;
      int               ch;
      bit               fits;
      bit               found;
      bit               stop;
      logic [TAG_W-1:0] old;
      res = '0;
      if (mode == MODE_RELEASE) begin
         // clear upward, stop after the run's top tag (1) or a free channel
         stop = 1'b0;
         for (ch = int'(chan); ch < NCH && !stop; ch++) begin
            old           = chan_tags[ch];
            chan_tags[ch] = '0;
            stop          = (old <= 1);
         end
         res.success = 1'b1;
      end else begin
         n     = int'(count);
         found = 1'b0;
         if (TXC == NCH) begin
            lo = 0;
            hi = NCH - 1;
         end else if (dir == DIR_TX) begin
            lo = 0;
            hi = TX_TOP;
         end else begin
            lo = RX_LOW;
            hi = NCH - 1;
         end
         // downward search; a run must lie wholly within [lo, hi]
         if (n > 0) begin
            for (top = hi; top - n + 1 >= lo && !found; top--) begin
               fits = 1'b1;
               for (k = 0; k < n; k++)
                  if (chan_tags[top - k] != '0) fits = 1'b0;
               if (fits) begin
                  for (k = 0; k < n; k++)
                     chan_tags[top - k] = TAG_W'(k + 1);
                  found        = 1'b1;
                  res.success  = 1'b1;
                  res.base     = CHAN_W'(top - n + 1);
               end
            end
         end
      end
      return res;
   endfunction

   // One request transaction; valid is left high for a back-to-back follow-up
   task automatic send_request(input logic mode, input logic dir,
                               input logic [COUNT_W-1:0] count,
                               input logic [CHAN_W-1:0] chan,
                               output outcome_type outcome);
      int gap;
      gap = pick_gap(req_idle_on);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid           <= 1'b1;
      req_chan.mode            <= mode;
      req_chan.direction       <= dir;
      req_chan.block_count     <= count;
      req_chan.release_channel <= chan;
      do @(posedge clock); while (!req_chan.ready);
      outcome = predict_outcome(mode, dir, count, chan);
      expected_outcomes.push_back(outcome);
      if (mode == MODE_RELEASE)
         n_released++;
      else if (outcome.success)
         n_granted++;
      else
         n_refused++;
   endtask

   task automatic alloc_req(input logic dir, input int count);
      outcome_type o;
      send_request(MODE_ALLOC, dir, COUNT_W'(count), CHAN_W'($urandom_range(0, NCH - 1)), o);
   endtask

   task automatic release_req(input int chan);
      outcome_type o;
      send_request(MODE_RELEASE, 1'($urandom_range(0, 1)), COUNT_W'($urandom_range(0, 15)),
                   CHAN_W'(chan), o);
   endtask

   // Response acceptance with random stalls
   initial begin : rsp_ready_gen
      int stall_left;
      stall_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap(rsp_stall_on);
         end
      end
   end

   // Compare every accepted response with the oldest prediction
   always @(posedge clock) begin : check_results
      outcome_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_outcomes.size() == 0) begin
            report_mismatch($sformatf("unexpected response success=%0b base=%0d",
                                      rsp_chan.success, rsp_chan.base_channel));
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_chan.success !== want.success)
               report_mismatch($sformatf("success %0b, expected %0b",
                                         rsp_chan.success, want.success));
            if (rsp_chan.base_channel !== want.base)
               report_mismatch($sformatf("base_channel %0d, expected %0d",
                                         rsp_chan.base_channel, want.base));
         end
      end
   end

   // Zero counts, full and oversize ranges, runs crossing the range bottom,
   // partial and orphaned releases, releases at free channels
   task automatic test_directed();
      alloc_req(DIR_TX, 0);
      alloc_req(DIR_RX, 0);
      alloc_req(DIR_TX, 4);
      alloc_req(DIR_TX, 1);
      alloc_req(DIR_RX, 8);
      alloc_req(DIR_RX, 2);
      alloc_req(DIR_RX, 3);
      alloc_req(DIR_RX, 2);
      alloc_req(DIR_RX, 1);
      release_req(6);
      release_req(2);
      alloc_req(DIR_TX, 2);
      release_req(6);
      release_req(0);
      release_req(4);
      release_req(7);
      alloc_req(DIR_TX, 3);
      alloc_req(DIR_TX, 1);
      alloc_req(DIR_RX, 4);
      alloc_req(DIR_TX, 5);
      release_req(0);
      release_req(1);
      release_req(4);
      alloc_req(DIR_RX, 1);
   endtask

   // Mostly allocate/release pairs on live runs, with some stray releases
   task automatic test_random_traffic(input int n_items);
      outcome_type o;
      int          live_bases [$];
      int          r;
      int          c;
      int          idx;
      logic        dir;
      for (int i = 0; i < n_items; i++) begin
         r = $urandom_range(0, 99);
         if (r < 50) begin
            c   = $urandom_range(0, 99);
            c   = (c < 5) ? 0 : (c < 85) ? $urandom_range(1, 4) : $urandom_range(5, 8);
            dir = 1'($urandom_range(0, 1));
            send_request(MODE_ALLOC, dir, COUNT_W'(c), CHAN_W'($urandom_range(0, NCH - 1)), o);
            if (o.success) live_bases.push_back(int'(o.base));
         end else if (r < 88 && live_bases.size() > 0) begin
            idx = $urandom_range(0, live_bases.size() - 1);
            release_req(live_bases[idx]);
            live_bases.delete(idx);
         end else begin
            release_req($urandom_range(0, NCH - 1));
         end
      end
   endtask

   task automatic wait_drain();
      int waited;
      waited = 0;
      while (expected_outcomes.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_outcomes.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", expected_outcomes.size()));
      repeat (SETTLE) @(posedge clock);
   endtask

   // Main sequence
   initial begin
      error_count  = 0;
      n_granted    = 0;
      n_refused    = 0;
      n_released   = 0;
      req_idle_on  = 1'b1;
      rsp_stall_on = 1'b1;
      for (int i = 0; i < NCH; i++) chan_tags[i] = '0;
      reset                    = 1'b1;
      req_chan.valid           <= 1'b0;
      req_chan.mode            <= MODE_ALLOC;
      req_chan.direction       <= DIR_TX;
      req_chan.block_count     <= '0;
      req_chan.release_channel <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_traffic(700);
      // back-to-back stretch with no idling on either side
      req_idle_on  = 1'b0;
      rsp_stall_on = 1'b0;
      test_random_traffic(300);
      req_idle_on  = 1'b1;
      rsp_stall_on = 1'b1;
      test_random_traffic(200);
      @(posedge clock);
      req_chan.valid <= 1'b0;
      wait_drain();

      $display("tb: %0d allocations granted, %0d refused, %0d releases checked",
               n_granted, n_refused, n_released);
      $display("tb: %0d mismatches", error_count);
      if (error_count == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule

`default_nettype wire
